>>> rtl/core/assert_macros.svh
// Assertion helpers; compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CHK_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("check failed");
`define CHK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error("check failed");
`else
`define CHK_ALWAYS(label, clk, rst, prop)
`define CHK_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/core/smea_pkg.sv
package smea_pkg;

   localparam int StackDepthDef = 16;
   localparam int DivCntW = 4;

   typedef enum logic [2:0] {
      STAT_OK      = 3'd0,
      STAT_OVER    = 3'd1,
      STAT_UNDER   = 3'd2,
      STAT_DIVZ    = 3'd3,
      STAT_CHECK   = 3'd4,
      STAT_ILLEGAL = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_EXEC, S_DIV, S_WRITE0, S_WRITE1, S_RESP
   } state_type;

   localparam logic [7:0] OP_LIB  = 8'o020;
   localparam logic [7:0] OP_LIW  = 8'o022;
   localparam logic [7:0] OP_DADD = 8'o210;
   localparam logic [7:0] OP_DSUB = 8'o211;
   localparam logic [7:0] OP_DMUL = 8'o212;
   localparam logic [7:0] OP_DSHL = 8'o216;
   localparam logic [7:0] OP_DSHR = 8'o217;
   localparam logic [7:0] OP_UCHK = 8'o245;
   localparam logic [7:0] OP_ULSS = 8'o252;
   localparam logic [7:0] OP_ULEQ = 8'o253;
   localparam logic [7:0] OP_UGTR = 8'o254;
   localparam logic [7:0] OP_UGEQ = 8'o255;
   localparam logic [7:0] OP_COPT = 8'o265;
   localparam logic [7:0] OP_UADD = 8'o270;
   localparam logic [7:0] OP_USUB = 8'o271;
   localparam logic [7:0] OP_UMUL = 8'o272;
   localparam logic [7:0] OP_UDIV = 8'o273;
   localparam logic [7:0] OP_UMOD = 8'o274;
   localparam logic [7:0] OP_ROR  = 8'o275;
   localparam logic [7:0] OP_SHL  = 8'o276;
   localparam logic [7:0] OP_SHR  = 8'o277;
   localparam logic [7:0] OP_CHK  = 8'o305;
   localparam logic [7:0] OP_CHKZ = 8'o306;
   localparam logic [7:0] OP_CHKS = 8'o307;
   localparam logic [7:0] OP_EQL  = 8'o310;
   localparam logic [7:0] OP_NEQ  = 8'o311;
   localparam logic [7:0] OP_LSS  = 8'o312;
   localparam logic [7:0] OP_LEQ  = 8'o313;
   localparam logic [7:0] OP_GTR  = 8'o314;
   localparam logic [7:0] OP_GEQ  = 8'o315;
   localparam logic [7:0] OP_ABS  = 8'o316;
   localparam logic [7:0] OP_NEG  = 8'o317;
   localparam logic [7:0] OP_OR   = 8'o320;
   localparam logic [7:0] OP_XOR  = 8'o321;
   localparam logic [7:0] OP_AND  = 8'o322;
   localparam logic [7:0] OP_COM  = 8'o323;
   localparam logic [7:0] OP_IN   = 8'o324;
   localparam logic [7:0] OP_LIN  = 8'o325;
   localparam logic [7:0] OP_MSK  = 8'o326;
   localparam logic [7:0] OP_NOT  = 8'o327;
   localparam logic [7:0] OP_ADD  = 8'o330;
   localparam logic [7:0] OP_SUB  = 8'o331;
   localparam logic [7:0] OP_MUL  = 8'o332;
   localparam logic [7:0] OP_DIV  = 8'o333;
   localparam logic [7:0] OP_MOD  = 8'o334;
   localparam logic [7:0] OP_BIT  = 8'o335;
   localparam logic [7:0] OP_NOP  = 8'o336;

   typedef struct packed {
      logic       accept;
      logic       rd;
      logic [2:0] rd_step;
      logic       exec;
      logic       div_step;
      logic       wr0;
      logic       wr1;
   } cmd_type;

   typedef struct packed {
      logic div_go;
   } sts_type;

endpackage

>>> rtl/core/smea_ctrl.sv
module smea_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  smea_pkg::sts_type sts,
   output smea_pkg::cmd_type cmd
);
   import smea_pkg::*;

   state_type          state_ff, state_in;
   logic [2:0]         step_ff, step_in;
   logic [DivCntW-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
            step_in    = '0;
            if (req_valid) state_in = S_READ;
         end
         S_READ: begin
            cmd.rd      = 1'b1;
            cmd.rd_step = step_ff;
            step_in     = step_ff + 3'd1;
            if (step_ff == 3'd4) state_in = S_EXEC;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            cnt_in   = '0;
            state_in = sts.div_go ? S_DIV : S_WRITE0;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == '1) state_in = S_WRITE0;
         end
         S_WRITE0: begin
            cmd.wr0  = 1'b1;
            state_in = S_WRITE1;
         end
         S_WRITE1: begin
            cmd.wr1  = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

>>> rtl/core/smea_dpath.sv
`include "assert_macros.svh"
module smea_dpath #(
   parameter int STACK_DEPTH = smea_pkg::StackDepthDef,
   parameter int CW = $clog2(STACK_DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  smea_pkg::cmd_type cmd,
   output smea_pkg::sts_type sts,
   input  logic [7:0]        req_type,
   input  logic [15:0]       req_immediate,
   input  logic              cfg_we,
   input  logic              cfg_checks,
   output logic [15:0]       top_word,
   output logic [15:0]       second_word,
   output logic [CW-1:0]     depth,
   output logic [2:0]        status
);
   import smea_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);

   logic [15:0]   mem [STACK_DEPTH];
   logic [15:0]   rdata_ff;
   logic [AW-1:0] raddr, waddr;
   logic [15:0]   wdata;
   logic          we;

   logic          checks_ff;
   logic [CW-1:0] count_ff;
   logic [7:0]    op_ff;
   logic [15:0]   imm_ff;
   logic [15:0]   opnd_ff [4];
   logic [15:0]   x, y, z, w;

   logic [15:0]   r0_ff, r1_ff;
   logic [2:0]    npop_ff, npush_ff;
   status_type    status_ff;
   logic          use_div_ff;

   logic [15:0]   dq_ff, dsor_ff;
   logic [16:0]   drem_ff;
   logic          neg_q_ff, neg_r_ff, want_rem_ff;

   logic [15:0]   top_ff, sec_ff;
   logic [CW-1:0] depth_ff;
   status_type    stat_ff;

   logic [15:0]   r0_c, r1_c;
   logic [2:0]    npop_c, npush_c;
   logic          legal_c, dz_c, fail_c, isdiv_c, sgn_c, rem_c;
   status_type    status_c;
   logic [31:0]   prod, dsum, ddif;
   logic [CW:0]   cnt_ext, new_cnt;
   logic [16:0]   trial;
   logic [15:0]   q_fix, r_fix, wd0;
   logic [CW-1:0] base;
   logic [2:0]    cap_idx;

   assign x = opnd_ff[0];
   assign y = opnd_ff[1];
   assign z = opnd_ff[2];
   assign w = opnd_ff[3];

   // stack memory
   assign raddr = AW'(count_ff - CW'(1) - CW'(cmd.rd_step));
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) checks_ff <= 1'b1;
      else if (cfg_we) checks_ff <= cfg_checks;
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff  <= req_type;
         imm_ff <= req_immediate;
      end
   end

   assign cap_idx = cmd.rd_step - 3'd1;
   always_ff @(posedge clock) begin
      if (cmd.rd && cmd.rd_step != 3'd0) begin
         opnd_ff[cap_idx[1:0]] <= (CW'(cap_idx) < count_ff) ? rdata_ff : 16'h0000;
      end
   end

   // opcode decode
   assign prod = y * x;
   assign dsum = {z, w} + {x, y};
   assign ddif = {z, w} - {x, y};
   assign cnt_ext = {1'b0, count_ff};

   always_comb begin
      r0_c    = '0;
      r1_c    = '0;
      npop_c  = '0;
      npush_c = '0;
      legal_c = 1'b1;
      dz_c    = 1'b0;
      fail_c  = 1'b0;
      isdiv_c = 1'b0;
      sgn_c   = 1'b0;
      rem_c   = 1'b0;
      if (op_ff[7:4] == 4'h0) begin
         npush_c = 3'd1;
         r0_c    = {12'h000, op_ff[3:0]};
      end else begin
         case (op_ff)
            OP_LIB: begin npush_c = 3'd1; r0_c = {8'h00, imm_ff[7:0]}; end
            OP_LIW: begin npush_c = 3'd1; r0_c = imm_ff; end
            OP_DADD: begin
               npop_c = 3'd4; npush_c = 3'd2; r0_c = dsum[15:0]; r1_c = dsum[31:16];
            end
            OP_DSUB: begin
               npop_c = 3'd4; npush_c = 3'd2; r0_c = ddif[15:0]; r1_c = ddif[31:16];
            end
            OP_DMUL: begin
               npop_c = 3'd2; npush_c = 3'd2; r0_c = prod[15:0]; r1_c = prod[31:16];
            end
            OP_DSHL: begin
               npop_c = 3'd2; npush_c = 3'd2; r0_c = {y[14:0], 1'b0}; r1_c = {x[14:0], y[15]};
            end
            OP_DSHR: begin
               npop_c = 3'd2; npush_c = 3'd2; r0_c = {x[0], y[15:1]}; r1_c = {x[15], x[15:1]};
            end
            OP_UCHK: begin
               npop_c = 3'd3; npush_c = 3'd1; r0_c = z; fail_c = (z < y) || (z > x);
            end
            OP_ULSS: begin npop_c = 3'd2; npush_c = 3'd1; r0_c = {15'h0, y < x}; end
            OP_ULEQ: begin npop_c = 3'd2; npush_c = 3'd1; r0_c = {15'h0, y <= x}; end
            OP_UGTR: begin npop_c = 3'd2; npush_c = 3'd1; r0_c = {15'h0, y > x}; end
            OP_UGEQ: begin npop_c = 3'd2; npush_c = 3'd1; r0_c = {15'h0, y >= x}; end
            OP_COPT: begin npop_c = 3'd1; npush_c = 3'd2; r0_c = x; r1_c = x; end
            OP_UADD, OP_ADD: begin npop_c = 3'd2; npush_c = 3'd1; r0_c = y + x; end
            OP_USUB, OP_SUB: begin npop_c = 3'd2; npush_c = 3'd1; r0_c = y - x; end
            OP_UMUL, OP_MUL: begin npop_c = 3'd2; npush_c = 3'd1; r0_c = prod[15:0]; end
            OP_UDIV: begin
               npop_c = 3'd2; npush_c = 3'd1; dz_c = (x == 16'h0); isdiv_c = 1'b1;
            end
            OP_UMOD: begin
               npop_c = 3'd2; npush_c = 3'd1; dz_c = (x == 16'h0); isdiv_c = 1'b1;
               rem_c = 1'b1;
            end
            OP_DIV: begin
               npop_c = 3'd2; npush_c = 3'd1; dz_c = (x == 16'h0); isdiv_c = 1'b1;
               sgn_c = 1'b1;
            end
            OP_MOD: begin
               npop_c = 3'd2; npush_c = 3'd1; dz_c = (x == 16'h0); isdiv_c = 1'b1;
               sgn_c = 1'b1; rem_c = 1'b1;
            end
            OP_ROR: begin
               npop_c = 3'd2; npush_c = 3'd1;
               r0_c = 16'({y, y} >> x[3:0]);
            end
            OP_SHL: begin npop_c = 3'd2; npush_c = 3'd1; r0_c = y << x[3:0]; end
            OP_SHR: begin npop_c = 3'd2; npush_c = 3'd1; r0_c = y >> x[3:0]; end
            OP_CHK: begin
               npop_c = 3'd3; npush_c = 3'd1; r0_c = z;
               fail_c = ($signed(z) < $signed(y)) || ($signed(z) > $signed(x));
            end
            OP_CHKZ: begin npop_c = 3'd2; npush_c = 3'd1; r0_c = y; fail_c = y > x; end
            OP_CHKS: begin npop_c = 3'd1; npush_c = 3'd1; r0_c = x; fail_c = x[15]; end
            OP_EQL: begin npop_c = 3'd2; npush_c = 3'd1; r0_c = {15'h0, y == x}; end
            OP_NEQ: begin npop_c = 3'd2; npush_c = 3'd1; r0_c = {15'h0, y != x}; end
            OP_LSS: begin
               npop_c = 3'd2; npush_c = 3'd1; r0_c = {15'h0, $signed(y) < $signed(x)};
            end
            OP_LEQ: begin
               npop_c = 3'd2; npush_c = 3'd1; r0_c = {15'h0, $signed(y) <= $signed(x)};
            end
            OP_GTR: begin
               npop_c = 3'd2; npush_c = 3'd1; r0_c = {15'h0, $signed(y) > $signed(x)};
            end
            OP_GEQ: begin
               npop_c = 3'd2; npush_c = 3'd1; r0_c = {15'h0, $signed(y) >= $signed(x)};
            end
            OP_ABS: begin npop_c = 3'd1; npush_c = 3'd1; r0_c = x[15] ? -x : x; end
            OP_NEG: begin npop_c = 3'd1; npush_c = 3'd1; r0_c = -x; end
            OP_OR:  begin npop_c = 3'd2; npush_c = 3'd1; r0_c = y | x; end
            OP_XOR: begin npop_c = 3'd2; npush_c = 3'd1; r0_c = y ^ x; end
            OP_AND: begin npop_c = 3'd2; npush_c = 3'd1; r0_c = y & x; end
            OP_COM: begin npop_c = 3'd1; npush_c = 3'd1; r0_c = ~x; end
            OP_IN: begin
               npop_c = 3'd2; npush_c = 3'd1;
               r0_c = {15'h0, (y <= 16'd15) && (((16'h8000 >> y[3:0]) & x) != 16'h0)};
            end
            OP_LIN: begin npush_c = 3'd1; r0_c = 16'hFFFF; end
            OP_MSK: begin npop_c = 3'd1; npush_c = 3'd1; r0_c = ~(16'hFFFF >> x[3:0]); end
            OP_NOT: begin npop_c = 3'd1; npush_c = 3'd1; r0_c = {15'h0, x == 16'h0}; end
            OP_BIT: begin
               npop_c = 3'd1; npush_c = 3'd1;
               r0_c = (x < 16'd16) ? (16'h8000 >> x[3:0]) : 16'h0000;
            end
            OP_NOP: ;
            default: legal_c = 1'b0;
         endcase
      end

      if (!legal_c) status_c = STAT_ILLEGAL;
      else if (cnt_ext < (CW+1)'(npop_c)) status_c = STAT_UNDER;
      else if (cnt_ext - (CW+1)'(npop_c) + (CW+1)'(npush_c) > (CW+1)'(STACK_DEPTH))
         status_c = STAT_OVER;
      else if (dz_c) status_c = STAT_DIVZ;
      else if (fail_c && checks_ff) status_c = STAT_CHECK;
      else status_c = STAT_OK;
   end

   assign sts.div_go = isdiv_c && (status_c == STAT_OK);

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         r0_ff      <= r0_c;
         r1_ff      <= r1_c;
         npop_ff    <= npop_c;
         npush_ff   <= npush_c;
         status_ff  <= status_c;
         use_div_ff <= sts.div_go;
      end
   end

   // restoring divider, one quotient bit per cycle
   assign trial = {drem_ff[15:0], dq_ff[15]} - {1'b0, dsor_ff};
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         dq_ff       <= (sgn_c && y[15]) ? -y : y;
         dsor_ff     <= (sgn_c && x[15]) ? -x : x;
         drem_ff     <= '0;
         neg_q_ff    <= sgn_c && (y[15] ^ x[15]);
         neg_r_ff    <= sgn_c && y[15];
         want_rem_ff <= rem_c;
      end else if (cmd.div_step) begin
         drem_ff <= trial[16] ? {drem_ff[15:0], dq_ff[15]} : trial;
         dq_ff   <= {dq_ff[14:0], ~trial[16]};
      end
   end

   assign q_fix = neg_q_ff ? -dq_ff : dq_ff;
   assign r_fix = neg_r_ff ? -drem_ff[15:0] : drem_ff[15:0];
   assign wd0   = use_div_ff ? (want_rem_ff ? r_fix : q_fix) : r0_ff;

   // write-back
   assign base    = count_ff - CW'(npop_ff);
   assign new_cnt = {1'b0, base} + (CW+1)'(npush_ff);
   always_comb begin
      we    = 1'b0;
      waddr = AW'(base);
      wdata = wd0;
      if (cmd.wr0) begin
         we = (status_ff == STAT_OK) && (npush_ff != 3'd0);
      end else if (cmd.wr1) begin
         we    = (status_ff == STAT_OK) && (npush_ff == 3'd2);
         waddr = AW'(base + CW'(1));
         wdata = r1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else if (cmd.wr1 && status_ff == STAT_OK) count_ff <= CW'(new_cnt);
   end

   always_ff @(posedge clock) begin
      if (cmd.wr1) begin
         stat_ff <= status_ff;
         if (status_ff != STAT_OK || npush_ff == 3'd0) begin
            top_ff   <= x;
            sec_ff   <= y;
            depth_ff <= count_ff;
         end else if (npush_ff == 3'd2) begin
            top_ff   <= r1_ff;
            sec_ff   <= wd0;
            depth_ff <= CW'(new_cnt);
         end else begin
            top_ff   <= wd0;
            sec_ff   <= opnd_ff[npop_ff[1:0]];
            depth_ff <= CW'(new_cnt);
         end
      end
   end

   assign top_word    = top_ff;
   assign second_word = sec_ff;
   assign depth       = depth_ff;
   assign status      = stat_ff;

   `CHK_ALWAYS(a_count_bound, clock, reset, count_ff <= CW'(STACK_DEPTH))
   `CHK_NEXT(a_depth_match, clock, reset, cmd.wr1, depth_ff == count_ff)
   `CHK_NEXT(a_err_no_change, clock, reset, cmd.wr1 && status_ff != STAT_OK, count_ff == $past(count_ff))

endmodule

>>> rtl/core/stack_machine_expression_alu.sv
// A request passes through the read, execute and write states to the response state;
// UDIV, UMOD, DIV and MOD with no error also pass through a 16-step radix-2 divider.
// Throughput: one item in flight; a new request is taken only after the result transfer.
// Operand fetch goes through the single stack memory read port.
// Reset (synchronous, active high): empty stack, checks enabled, idle.
module stack_machine_expression_alu #(
   parameter int STACK_DEPTH = smea_pkg::StackDepthDef,
   parameter int CW = $clog2(STACK_DEPTH + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [7:0]    req_type,
   input  logic [15:0]   req_immediate,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [15:0]   rsp_top_word,
   output logic [15:0]   rsp_second_word,
   output logic [CW-1:0] rsp_depth,
   output logic [2:0]    rsp_status,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic          csr_checks_enabled
);
   import smea_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   smea_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   smea_dpath #(
      .STACK_DEPTH (STACK_DEPTH),
      .CW          (CW)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_type      (req_type),
      .req_immediate (req_immediate),
      .cfg_we        (csr_valid && csr_ready),
      .cfg_checks    (csr_checks_enabled),
      .top_word      (rsp_top_word),
      .second_word   (rsp_second_word),
      .depth         (rsp_depth),
      .status        (rsp_status)
   );

endmodule

>>> dv/stack_machine_expression_alu_tb.sv
module stack_machine_expression_alu_tb;
   import smea_pkg::*;

   typedef struct packed {
      logic [15:0] top_word;
      logic [15:0] second_word;
      logic [4:0]  depth;
      logic [2:0]  status;
   } alu_result_type;

   class alu_scoreboard;
      logic [15:0] words [16];
      int unsigned count;
      bit checks_on;
      alu_result_type pending[$];
      int unsigned mismatches;

      function new();
         count = 0;
         checks_on = 1;
         mismatches = 0;
         foreach (words[k]) words[k] = '0;
      endfunction

      function logic [15:0] peek(int unsigned k);
         if (k < count) return words[count - 1 - k];
         return '0;
      endfunction

      function void note_request(logic [7:0] op, logic [15:0] imm);
         logic [15:0] x, y, z, w;
         logic signed [15:0] sx, sy, sz;
         logic [31:0] d, e, r0, r1;
         int unsigned npop, npush, n;
         bit legal, dz, fail;
         logic [2:0] st;
         alu_result_type res;
         x = peek(0); y = peek(1); z = peek(2); w = peek(3);
         sx = x; sy = y; sz = z;
         r0 = 0; r1 = 0; npop = 0; npush = 0;
         legal = 1; dz = 0; fail = 0;
         if (op < 8'o20) begin
            npush = 1; r0 = op;
         end else begin
            case (op)
               OP_LIB: begin npush = 1; r0 = imm[7:0]; end
               OP_LIW: begin npush = 1; r0 = imm; end
               OP_DADD, OP_DSUB: begin
                  npop = 4; npush = 2;
                  d = {z, w}; e = {x, y};
                  d = (op == OP_DADD) ? d + e : d - e;
                  r0 = d[15:0]; r1 = d[31:16];
               end
               OP_DMUL: begin
                  npop = 2; npush = 2; d = y * x;
                  r0 = d[15:0]; r1 = d[31:16];
               end
               OP_DSHL, OP_DSHR: begin
                  npop = 2; npush = 2; d = {x, y};
                  d = (op == OP_DSHL) ? d << 1 : {d[31], d[31:1]};
                  r0 = d[15:0]; r1 = d[31:16];
               end
               OP_UCHK: begin npop = 3; npush = 1; r0 = z; fail = (z < y) || (z > x); end
               OP_ULSS: begin npop = 2; npush = 1; r0 = y < x; end
               OP_ULEQ: begin npop = 2; npush = 1; r0 = y <= x; end
               OP_UGTR: begin npop = 2; npush = 1; r0 = y > x; end
               OP_UGEQ: begin npop = 2; npush = 1; r0 = y >= x; end
               OP_COPT: begin npop = 1; npush = 2; r0 = x; r1 = x; end
               OP_UADD, OP_ADD: begin npop = 2; npush = 1; r0 = y + x; end
               OP_USUB, OP_SUB: begin npop = 2; npush = 1; r0 = y - x; end
               OP_UMUL, OP_MUL: begin npop = 2; npush = 1; r0 = y * x; end
               OP_UDIV: begin npop = 2; npush = 1; dz = x == 0; r0 = dz ? 0 : y / x; end
               OP_UMOD: begin npop = 2; npush = 1; dz = x == 0; r0 = dz ? 0 : y % x; end
               OP_ROR: begin
                  npop = 2; npush = 1; n = x[3:0];
                  r0 = ({y, y} >> n);
                  r0 = r0[15:0];
               end
               OP_SHL: begin npop = 2; npush = 1; r0 = y << x[3:0]; end
               OP_SHR: begin npop = 2; npush = 1; r0 = y >> x[3:0]; end
               OP_CHK: begin npop = 3; npush = 1; r0 = z; fail = (sz < sy) || (sz > sx); end
               OP_CHKZ: begin npop = 2; npush = 1; r0 = y; fail = y > x; end
               OP_CHKS: begin npop = 1; npush = 1; r0 = x; fail = sx < 0; end
               OP_EQL: begin npop = 2; npush = 1; r0 = y == x; end
               OP_NEQ: begin npop = 2; npush = 1; r0 = y != x; end
               OP_LSS: begin npop = 2; npush = 1; r0 = sy < sx; end
               OP_LEQ: begin npop = 2; npush = 1; r0 = sy <= sx; end
               OP_GTR: begin npop = 2; npush = 1; r0 = sy > sx; end
               OP_GEQ: begin npop = 2; npush = 1; r0 = sy >= sx; end
               OP_ABS: begin npop = 1; npush = 1; r0 = (sx < 0) ? 16'(-x) : x; end
               OP_NEG: begin npop = 1; npush = 1; r0 = 16'(-x); end
               OP_OR: begin npop = 2; npush = 1; r0 = y | x; end
               OP_XOR: begin npop = 2; npush = 1; r0 = y ^ x; end
               OP_AND: begin npop = 2; npush = 1; r0 = y & x; end
               OP_COM: begin npop = 1; npush = 1; r0 = 16'(~x); end
               OP_IN: begin
                  npop = 2; npush = 1;
                  r0 = (y <= 15) ? (((16'h8000 >> y) & x) != 0) : 0;
               end
               OP_LIN: begin npush = 1; r0 = 16'hFFFF; end
               OP_MSK: begin
                  npop = 1; npush = 1; n = x[3:0];
                  r0 = n ? 16'(16'hFFFF << (16 - n)) : 0;
               end
               OP_NOT: begin npop = 1; npush = 1; r0 = x == 0; end
               OP_DIV: begin
                  npop = 2; npush = 1; dz = x == 0;
                  if (!dz) r0 = (sx == -1) ? 16'(-y) : 16'(sy / sx);
               end
               OP_MOD: begin
                  npop = 2; npush = 1; dz = x == 0;
                  if (!dz) r0 = (sx == -1) ? 0 : 16'(sy % sx);
               end
               OP_BIT: begin npop = 1; npush = 1; r0 = (x < 16) ? (16'h8000 >> x) : 0; end
               OP_NOP: ;
               default: legal = 0;
            endcase
         end
         if (!legal) st = STAT_ILLEGAL;
         else if (count < npop) st = STAT_UNDER;
         else if (count - npop + npush > 16) st = STAT_OVER;
         else if (dz) st = STAT_DIVZ;
         else if (fail && checks_on) st = STAT_CHECK;
         else begin
            st = STAT_OK;
            count -= npop;
            if (npush > 0) words[count++] = r0[15:0];
            if (npush > 1) words[count++] = r1[15:0];
         end
         res.top_word = peek(0);
         res.second_word = peek(1);
         res.depth = 5'(count);
         res.status = st;
         pending.push_back(res);
      endfunction

      function void check_result(alu_result_type got);
         alu_result_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transfer %h", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: top %h/%h second %h/%h depth %0d/%0d status %0d/%0d",
                        want.top_word, got.top_word, want.second_word, got.second_word,
                        want.depth, got.depth, want.status, got.status);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [7:0] req_type = '0;
   logic [15:0] req_immediate = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [15:0] rsp_top_word, rsp_second_word;
   logic [4:0] rsp_depth;
   logic [2:0] rsp_status;
   logic csr_valid = 0;
   logic csr_ready;
   logic csr_checks_enabled = 0;

   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   alu_scoreboard board;

   stack_machine_expression_alu i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_type(req_type), .req_immediate(req_immediate),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_top_word(rsp_top_word), .rsp_second_word(rsp_second_word),
      .rsp_depth(rsp_depth), .rsp_status(rsp_status),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_checks_enabled(csr_checks_enabled)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   initial begin
      #50_000_000;
      $display("[stack_machine_expression_alu] ERROR");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result({rsp_top_word, rsp_second_word, rsp_depth, rsp_status});
   end

   always @(negedge clock) begin
      if (reset) rsp_stall <= 0;
      else rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // valid stays up after a transfer until the next send or a drain drops it
   task automatic send_op(logic [7:0] op, logic [15:0] imm);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_type <= op;
      req_immediate <= imm;
      do @(posedge clock); while (req_stall);
      board.note_request(op, imm);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_checks(bit en);
      drain();
      csr_valid <= 1;
      csr_checks_enabled <= en;
      do @(posedge clock); while (!csr_ready);
      board.checks_on = en;
      @(negedge clock);
      csr_valid <= 0;
   endtask

   function automatic logic [15:0] rand_word();
      case ($urandom_range(5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h8000;
         3: return 16'($urandom_range(17));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] rand_op();
      logic [7:0] ops [] = '{OP_DADD, OP_DSUB, OP_DMUL, OP_DSHL, OP_DSHR, OP_UCHK,
         OP_ULSS, OP_ULEQ, OP_UGTR, OP_UGEQ, OP_COPT, OP_UADD, OP_USUB, OP_UMUL,
         OP_UDIV, OP_UMOD, OP_ROR, OP_SHL, OP_SHR, OP_CHK, OP_CHKZ, OP_CHKS,
         OP_EQL, OP_NEQ, OP_LSS, OP_LEQ, OP_GTR, OP_GEQ, OP_ABS, OP_NEG, OP_OR,
         OP_XOR, OP_AND, OP_COM, OP_IN, OP_LIN, OP_MSK, OP_NOT, OP_ADD, OP_SUB,
         OP_MUL, OP_DIV, OP_MOD, OP_BIT, OP_NOP};
      return ops[$urandom_range(ops.size() - 1)];
   endfunction

   task automatic random_phase(int unsigned items);
      int unsigned r;
      for (int i = 0; i < items; i++) begin
         r = $urandom_range(99);
         if (r < 3) send_op(8'($urandom), 16'($urandom));
         else if (r < 35 || board.count < 4) begin
            if ($urandom_range(2) == 0) send_op(8'($urandom_range(15)), 16'($urandom));
            else send_op($urandom_range(1) ? OP_LIW : OP_LIB, rand_word());
         end else send_op(rand_op(), 16'($urandom));
      end
   endtask

   initial begin
      board = new();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed
      send_op(OP_ADD, 0);
      send_op(8'o021, 0);
      send_op(8'o023, 0);
      send_op(8'hFF, 16'hFFFF);
      send_op(OP_LIW, 16'h8000);
      send_op(OP_LIW, 16'hFFFF);
      send_op(OP_DIV, 0);
      send_op(OP_LIW, 16'h8000);
      send_op(OP_ABS, 0);
      send_op(OP_NEG, 0);
      send_op(OP_LIB, 16'hFFAA);
      send_op(OP_LIB, 16'h0000);
      send_op(OP_DIV, 0);
      send_op(OP_MOD, 0);
      send_op(OP_BIT, 0);
      send_op(OP_MSK, 0);
      send_op(OP_LIN, 0);
      send_op(OP_LIN, 0);
      for (int i = 0; i < 16; i++) send_op(8'(i), 0);
      send_op(OP_NOP, 0);
      write_checks(0);
      send_op(OP_CHKS, 0);
      send_op(OP_UCHK, 0);
      write_checks(1);
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 84; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 84; end
            default: begin send_idle_pct = 23; recv_stall_pct = 23; end
         endcase
         random_phase(105);
         if (ph == 3) begin
            req_valid <= 0;
            while (board.pending.size() != 0) @(negedge clock);
            random_phase(5);
         end
         write_checks(ph[0]);
      end
      drain();
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("[stack_machine_expression_alu] OK");
      else
         $display("[stack_machine_expression_alu] ERROR");
      $finish;
   end
endmodule
